[rtl/lsmc_pkg.sv]
// ----------------------------------------------------------------------------
// lsmc_pkg
// Shared types and constants for the largest matching square block.
// ----------------------------------------------------------------------------
package lsmc_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;

  localparam int SIZE_W = 11;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] ROWS_RESET  = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] COLS_RESET  = SIZE_W'(1024);
  localparam logic [CHAR_W-1:0] MATCH_RESET = CHAR_W'(53);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS   = 2'd0,
    REG_NUM_COLS   = 2'd1,
    REG_MATCH_CHAR = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0] up;
    logic [SIZE_W-1:0] sq;
  } line_ent_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    line_ent_t        data;
  } line_wr_t;

endpackage

[rtl/lsmc_line_buf.sv]
// ----------------------------------------------------------------------------
// lsmc_line_buf
// Column line buffer holding the upward run and square side of the previous
// row, with a registered read and write-to-read forwarding.
// ----------------------------------------------------------------------------
module lsmc_line_buf (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [lsmc_pkg::COL_W-1:0] rd_addr,
  input  lsmc_pkg::line_wr_t       wr,
  output lsmc_pkg::line_ent_t      rd_data
);
  import lsmc_pkg::*;

  line_ent_t mem [MAX_COLS];
  line_ent_t rd_q;
  line_ent_t fwd_q;
  logic      fwd;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      fwd_q <= wr.data;
    end
  end

  // take the word being written in the same cycle as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr.en && (wr.addr == rd_addr);
    end
  end

  assign rd_data = fwd ? fwd_q : rd_q;

endmodule

[rtl/largest_square_of_matching_cells.sv]
// ----------------------------------------------------------------------------
// largest_square_of_matching_cells
// Finds the largest square of cells equal to the match byte in a raster grid.
// ----------------------------------------------------------------------------
// Accepts one cell per clock cycle, sustained, in raster order. Each cell is
// looked up in a line buffer with one read and one write port in the cycle it
// is accepted and resolved in the back stage from the registered read, which
// sets out_valid when it takes the last cell of a grid. The result register
// lets the next grid stream in while a result waits; input stalls only if a
// second grid finishes before the first result is taken. No clearing pass is
// needed after reset. Reported corner is one-based; a grid with no match
// reports side 0 at clamped num_rows+1, clamped num_cols+1.
module largest_square_of_matching_cells (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lsmc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lsmc_pkg::SIZE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lsmc_pkg::CHAR_W-1:0]   cell_req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lsmc_pkg::SIZE_W-1:0]   side,
  output logic [lsmc_pkg::SIZE_W-1:0]   top_row,
  output logic [lsmc_pkg::SIZE_W-1:0]   left_col
);
  import lsmc_pkg::*;

  logic [SIZE_W-1:0] num_rows;
  logic [SIZE_W-1:0] num_cols;
  logic [CHAR_W-1:0] match_char;

  logic [ROW_W-1:0]  row_index;
  logic [COL_W-1:0]  col_index;
  logic [SIZE_W-1:0] left_run;
  logic [SIZE_W-1:0] left_run_next;

  logic              s1_valid;
  logic              s1_hit;
  logic              s1_last;
  logic [ROW_W-1:0]  s1_row;
  logic [COL_W-1:0]  s1_col;
  logic [SIZE_W-1:0] s1_left;
  logic              s1_go;

  logic [SIZE_W-1:0] diag_square;
  logic [SIZE_W-1:0] best_side;
  logic [ROW_W-1:0]  best_row;
  logic [COL_W-1:0]  best_col;

  logic [SIZE_W-1:0] rows_eff;
  logic [SIZE_W-1:0] cols_eff;
  logic              hit;
  logic              row_end;
  logic              grid_end;
  logic              accept;

  line_ent_t         rd_data;
  line_wr_t          wr;

  logic [SIZE_W-1:0] up;
  logic [SIZE_W-1:0] sq;
  logic [SIZE_W-1:0] m1;
  logic [SIZE_W-1:0] diag_inc;
  logic              better;
  logic [SIZE_W-1:0] win_side;
  logic [ROW_W-1:0]  win_row;
  logic [COL_W-1:0]  win_col;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows   <= ROWS_RESET;
      num_cols   <= COLS_RESET;
      match_char <= MATCH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_NUM_ROWS:   num_rows   <= cfg_data;
        REG_NUM_COLS:   num_cols   <= cfg_data;
        REG_MATCH_CHAR: match_char <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // front stage: position, left run, line buffer read
  always_comb begin
    if (num_rows == '0) begin
      rows_eff = SIZE_W'(1);
    end else if (num_rows > SIZE_W'(MAX_ROWS)) begin
      rows_eff = SIZE_W'(MAX_ROWS);
    end else begin
      rows_eff = num_rows;
    end
    if (num_cols == '0) begin
      cols_eff = SIZE_W'(1);
    end else if (num_cols > SIZE_W'(MAX_COLS)) begin
      cols_eff = SIZE_W'(MAX_COLS);
    end else begin
      cols_eff = num_cols;
    end
    hit      = (cell_req == match_char);
    row_end  = ((SIZE_W'(col_index) + SIZE_W'(1)) >= cols_eff);
    grid_end = row_end && ((SIZE_W'(row_index) + SIZE_W'(1)) >= rows_eff);
    if (!hit) begin
      left_run_next = '0;
    end else if (col_index == '0) begin
      left_run_next = SIZE_W'(1);
    end else begin
      left_run_next = left_run + SIZE_W'(1);
    end
  end

  assign s1_go    = !(s1_valid && s1_last && out_valid && !out_ready);
  assign in_ready = s1_go;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index <= '0;
      col_index <= '0;
      left_run  <= '0;
    end else if (accept) begin
      left_run <= left_run_next;
      if (row_end) begin
        col_index <= '0;
        row_index <= grid_end ? '0 : row_index + ROW_W'(1);
      end else begin
        col_index <= col_index + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_go) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit  <= hit;
      s1_last <= grid_end;
      s1_row  <= row_index;
      s1_col  <= col_index;
      s1_left <= left_run_next;
    end
  end

  lsmc_line_buf u_line (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col_index),
    .wr      (wr),
    .rd_data (rd_data)
  );

  // back stage: square side, best tracking, write back
  always_comb begin
    diag_inc = diag_square + SIZE_W'(1);
    if (!s1_hit) begin
      up = '0;
    end else if (s1_row == '0) begin
      up = SIZE_W'(1);
    end else begin
      up = rd_data.up + SIZE_W'(1);
    end
    m1 = (s1_left < up) ? s1_left : up;
    if (s1_row == '0 || s1_col == '0) begin
      sq = SIZE_W'(s1_hit);
    end else begin
      sq = (m1 < diag_inc) ? m1 : diag_inc;
    end
    better   = (sq >= best_side);
    win_side = better ? sq : best_side;
    win_row  = better ? s1_row : best_row;
    win_col  = better ? s1_col : best_col;
    wr.en    = s1_valid && s1_go;
    wr.addr  = s1_col;
    wr.data.up = up;
    wr.data.sq = sq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diag_square <= '0;
      best_side   <= '0;
      best_row    <= '0;
      best_col    <= '0;
    end else if (wr.en) begin
      diag_square <= (s1_row == '0) ? '0 : rd_data.sq;
      if (s1_last) begin
        best_side <= '0;
        best_row  <= '0;
        best_col  <= '0;
      end else begin
        best_side <= win_side;
        best_row  <= win_row;
        best_col  <= win_col;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wr.en && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && s1_last) begin
      side     <= win_side;
      top_row  <= SIZE_W'(win_row) + SIZE_W'(2) - win_side;
      left_col <= SIZE_W'(win_col) + SIZE_W'(2) - win_side;
    end
  end

`ifndef SYNTH
  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && s1_last && out_valid))
    else $error("input stalled without a held result");

  a_grid_end_loads_result: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_go && s1_last) |=> out_valid)
    else $error("grid end did not load the result register");

  a_best_cleared_after_grid: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_go && s1_last) |=> (best_side == '0 && diag_square == '0 ||
                                        best_side == '0))
    else $error("best square not cleared at grid end");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the largest matching square block.
// ----------------------------------------------------------------------------
// Streams grids of cell bytes through the request channel under random source
// and sink idling. A short table covers reset values, a full-width row, the
// size and match byte extremes, an ignored register index, empty grids and
// size changes inside a grid. Random phases follow with small grids of varied
// fill density and some size or match byte changes mid-grid. Every reported
// square is compared field by field to a table entry or a line-buffer model.
// ----------------------------------------------------------------------------
module tb_top;
  import lsmc_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 5;
  localparam int SETTLE       = 4;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SMALL_CELLS  = 300;
  localparam int REPORT_MAX   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [SIZE_W-1:0] side;
    logic [SIZE_W-1:0] top_row;
    logic [SIZE_W-1:0] left_col;
  } square_t;

  typedef enum logic [1:0] {STEP_REG, STEP_CELLS} step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [SIZE_W-1:0]    value;
    logic [SIZE_W-1:0]    count;
    logic                 typed;
    square_t              want;
  } plan_step_t;

  localparam square_t NO_SQUARE = '0;

  localparam plan_step_t PLAN [0:27] = '{
    '{STEP_REG,   REG_NUM_ROWS,   11'd1,    11'd0,    1'b0, NO_SQUARE},
    '{STEP_CELLS, REG_NUM_ROWS,   11'h035,  11'd1024, 1'b1, '{11'd1, 11'd1, 11'd1024}},
    '{STEP_REG,   REG_NUM_COLS,   11'd1,    11'd0,    1'b0, NO_SQUARE},
    '{STEP_CELLS, REG_NUM_ROWS,   11'h035,  11'd1,    1'b1, '{11'd1, 11'd1, 11'd1}},
    '{STEP_CELLS, REG_NUM_ROWS,   11'h0CA,  11'd1,    1'b1, '{11'd0, 11'd2, 11'd2}},
    '{STEP_REG,   REG_MATCH_CHAR, 11'h0FF,  11'd0,    1'b0, NO_SQUARE},
    '{STEP_REG,   REG_NUM_ROWS,   11'd2,    11'd0,    1'b0, NO_SQUARE},
    '{STEP_REG,   REG_NUM_COLS,   11'd2,    11'd0,    1'b0, NO_SQUARE},
    '{STEP_CELLS, REG_NUM_ROWS,   11'h0FF,  11'd4,    1'b1, '{11'd2, 11'd1, 11'd1}},
    '{STEP_REG,   REG_MATCH_CHAR, 11'h700,  11'd0,    1'b0, NO_SQUARE},
    '{STEP_REG,   REG_NUM_ROWS,   11'd0,    11'd0,    1'b0, NO_SQUARE},
    '{STEP_REG,   REG_NUM_COLS,   11'd3,    11'd0,    1'b0, NO_SQUARE},
    '{STEP_CELLS, REG_NUM_ROWS,   11'h000,  11'd2,    1'b0, NO_SQUARE},
    '{STEP_CELLS, REG_NUM_ROWS,   11'h0FF,  11'd1,    1'b1, '{11'd1, 11'd1, 11'd2}},
    '{STEP_REG,   REG_SPARE,      11'h7FF,  11'd0,    1'b0, NO_SQUARE},
    '{STEP_REG,   REG_MATCH_CHAR, 11'h0A5,  11'd0,    1'b0, NO_SQUARE},
    '{STEP_REG,   REG_NUM_ROWS,   11'd3,    11'd0,    1'b0, NO_SQUARE},
    '{STEP_REG,   REG_NUM_COLS,   11'd3,    11'd0,    1'b0, NO_SQUARE},
    '{STEP_CELLS, REG_NUM_ROWS,   11'h05A,  11'd9,    1'b1, '{11'd0, 11'd4, 11'd4}},
    '{STEP_REG,   REG_NUM_COLS,   11'd2,    11'd0,    1'b0, NO_SQUARE},
    '{STEP_CELLS, REG_NUM_ROWS,   11'h0A5,  11'd2,    1'b0, NO_SQUARE},
    '{STEP_REG,   REG_NUM_ROWS,   11'd1,    11'd0,    1'b0, NO_SQUARE},
    '{STEP_CELLS, REG_NUM_ROWS,   11'h0A5,  11'd2,    1'b1, '{11'd2, 11'd1, 11'd1}},
    '{STEP_REG,   REG_NUM_ROWS,   11'd2,    11'd0,    1'b0, NO_SQUARE},
    '{STEP_REG,   REG_NUM_COLS,   11'd4,    11'd0,    1'b0, NO_SQUARE},
    '{STEP_CELLS, REG_NUM_ROWS,   11'h0A5,  11'd6,    1'b0, NO_SQUARE},
    '{STEP_REG,   REG_NUM_COLS,   11'd2,    11'd0,    1'b0, NO_SQUARE},
    '{STEP_CELLS, REG_NUM_ROWS,   11'h000,  11'd1,    1'b0, NO_SQUARE}
  };

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [SIZE_W-1:0]    cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [CHAR_W-1:0]    cell_req  = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SIZE_W-1:0]    side;
  logic [SIZE_W-1:0]    top_row;
  logic [SIZE_W-1:0]    left_col;

  largest_square_of_matching_cells u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cell_req  (cell_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .side      (side),
    .top_row   (top_row),
    .left_col  (left_col)
  );

  // register copies and scan state of the square tracker
  logic [SIZE_W-1:0] reg_rows;
  logic [SIZE_W-1:0] reg_cols;
  logic [CHAR_W-1:0] reg_match;
  logic [ROW_W-1:0]  scan_row;
  logic [COL_W-1:0]  scan_col;
  logic [SIZE_W-1:0] left_len;
  logic [SIZE_W-1:0] diag_len;
  logic [SIZE_W-1:0] best_len;
  logic [ROW_W-1:0]  best_r;
  logic [COL_W-1:0]  best_c;
  logic [SIZE_W-1:0] up_line [MAX_COLS];
  logic [SIZE_W-1:0] sq_line [MAX_COLS];

  square_t pending_squares [$];
  square_t typed_want;
  bit      typed_armed = 1'b0;
  bit      grid_done;
  int      src_max     = 8;
  int      sink_max    = 8;
  int      error_count = 0;
  int      cycle_count = 0;
  square_t got_square;
  square_t want_square;

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int clamp_dim(logic [SIZE_W-1:0] v, int lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic void clear_scan();
    scan_row = '0;
    scan_col = '0;
    left_len = '0;
    diag_len = '0;
    best_len = '0;
    best_r   = '0;
    best_c   = '0;
  endfunction

  function automatic bit feed_cell(input logic [CHAR_W-1:0] cell_val,
                                   output square_t res);
    int rows, cols, col, up, sq, above_sq;
    bit hit;
    rows     = clamp_dim(reg_rows, MAX_ROWS);
    cols     = clamp_dim(reg_cols, MAX_COLS);
    col      = int'(scan_col);
    hit      = (cell_val == reg_match);
    above_sq = 0;
    res      = '0;
    if (col == 0) left_len = '0;
    left_len = hit ? left_len + 11'd1 : 11'd0;
    if (scan_row != 0) begin
      up       = hit ? int'(up_line[col]) + 1 : 0;
      above_sq = int'(sq_line[col]);
    end else begin
      up = int'(hit);
    end
    if (scan_row == 0 || col == 0) begin
      sq = int'(hit);
    end else begin
      sq = int'(left_len);
      if (up < sq) sq = up;
      if (int'(diag_len) + 1 < sq) sq = int'(diag_len) + 1;
    end
    up_line[col] = SIZE_W'(up);
    sq_line[col] = SIZE_W'(sq);
    diag_len     = SIZE_W'(above_sq);
    if (sq >= int'(best_len)) begin
      best_len = SIZE_W'(sq);
      best_r   = scan_row;
      best_c   = COL_W'(col);
    end
    if (col + 1 >= cols) begin
      scan_col = '0;
      if (int'(scan_row) + 1 >= rows) begin
        res.side     = best_len;
        res.top_row  = SIZE_W'(int'(best_r) + 2 - int'(best_len));
        res.left_col = SIZE_W'(int'(best_c) + 2 - int'(best_len));
        clear_scan();
        return 1'b1;
      end
      scan_row = scan_row + 1'b1;
    end else begin
      scan_col = COL_W'(col + 1);
    end
    return 1'b0;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [SIZE_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_NUM_ROWS:   reg_rows = data;
      REG_NUM_COLS:   reg_cols = data;
      REG_MATCH_CHAR: reg_match = data[CHAR_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_cell(input logic [CHAR_W-1:0] cell_val, output bit done);
    int gap;
    square_t res;
    gap = (src_max > 0) ? $urandom_range(0, src_max) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_req <= cell_val;
    do @(posedge clk); while (!in_ready);
    done = feed_cell(cell_val, res);
    if (done) begin
      pending_squares.push_back(typed_armed ? typed_want : res);
      typed_armed = 1'b0;
    end
  endtask

  // drop valid, drain every pending square, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_squares.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] pick_cell(int density);
    if ($urandom_range(0, 99) < density) return reg_match;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_dim();
    if ($urandom_range(0, 9) == 0) return '0;
    return SIZE_W'($urandom_range(1, 8));
  endfunction

  task automatic report(input string what, input square_t want, input square_t got);
    error_count = error_count + 1;
    if (error_count <= REPORT_MAX)
      $display("%s at %0t: want side %0d top_row %0d left_col %0d, %s %0d %s %0d %s %0d",
               what, $time, want.side, want.top_row, want.left_col,
               "got side", got.side, "top_row", got.top_row,
               "left_col", got.left_col);
  endtask

  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_square = '{side, top_row, left_col};
      if (pending_squares.size() == 0) begin
        report("unexpected square", NO_SQUARE, got_square);
      end else begin
        want_square = pending_squares.pop_front();
        if (got_square.side !== want_square.side ||
            got_square.top_row !== want_square.top_row ||
            got_square.left_col !== want_square.left_col)
          report("square mismatch", want_square, got_square);
      end
    end
  end

  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = (sink_max > 0) ? $urandom_range(0, sink_max) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  initial begin
    int phase, small_cells, density, grids, sent, twist_at, grid_cells;
    reg_rows  = ROWS_RESET;
    reg_cols  = COLS_RESET;
    reg_match = MATCH_RESET;
    clear_scan();
    foreach (up_line[i]) begin
      up_line[i] = '0;
      sq_line[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == STEP_REG) begin
        settle();
        cfg_write(PLAN[i].idx, PLAN[i].value);
      end else begin
        typed_armed = PLAN[i].typed;
        typed_want  = PLAN[i].want;
        repeat (PLAN[i].count) send_cell(PLAN[i].value[CHAR_W-1:0], grid_done);
      end
    end

    phase       = 0;
    small_cells = 0;
    while (small_cells < SMALL_CELLS) begin
      settle();
      cfg_write(REG_NUM_ROWS, pick_dim());
      cfg_write(REG_NUM_COLS, pick_dim());
      cfg_write(REG_MATCH_CHAR, SIZE_W'($urandom_range(0, 2047)));
      if ($urandom_range(0, 7) == 0) cfg_write(REG_SPARE, SIZE_W'($urandom_range(0, 2047)));
      case ($urandom_range(0, 3))
        0: density = 0;
        1: density = 50;
        2: density = 85;
        default: density = 97;
      endcase
      src_max  = ($urandom_range(0, 3) == 0) ? 0 : 8;
      sink_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      grids    = $urandom_range(1, 3);
      grid_cells = clamp_dim(reg_rows, MAX_ROWS) * clamp_dim(reg_cols, MAX_COLS);
      twist_at = (grid_cells > 1 && $urandom_range(0, 5) == 0) ?
                 $urandom_range(1, grid_cells - 1) : 0;
      for (int g = 0; g < grids; g++) begin
        sent = 0;
        do begin
          send_cell(pick_cell(density), grid_done);
          sent = sent + 1;
          small_cells = small_cells + 1;
          // change one setting inside the grid, never widening a row
          if (g == 0 && sent == twist_at && !grid_done) begin
            settle();
            case ($urandom_range(0, 2))
              0: cfg_write(REG_NUM_ROWS, SIZE_W'($urandom_range(1, 8)));
              1: cfg_write(REG_MATCH_CHAR, SIZE_W'($urandom_range(0, 2047)));
              default: cfg_write(REG_NUM_COLS,
                                 SIZE_W'($urandom_range(1, clamp_dim(reg_cols, MAX_COLS))));
            endcase
          end
        end while (!grid_done);
      end
      phase = phase + 1;
    end

    settle();
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
